@@ rtl/i2cm_pkg.sv @@
// shared types and constants of the i2c master bit engine
package i2cm_pkg;

    localparam int PHASE_W    = 10;
    localparam int ACK_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int BITCNT_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST    = 10'd5;
    localparam logic [ACK_W-1:0]   ACK_WAIT_LIMIT_RST = 8'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT = 1'd1;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_START,
        KIND_STOP,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    // one classified tick as it waits in the queue
    typedef struct packed {
        logic              sda;
        kind_t             kind;
        logic [BYTE_W-1:0] tx;
        logic              ack;
    } tick_t;

    typedef struct packed {
        logic  valid;
        tick_t data;
    } tick_req_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic [BYTE_W-1:0] rx;
        logic nack;
        logic timeout;
    } result_t;

endpackage

@@ rtl/i2cm_if.sv @@
// handshake channels for ticks in and results out
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic       sda_in;
    logic       cmd_valid;
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       ack_to_send;

    modport source (output valid, sda_in, cmd_valid, command, tx_byte, ack_to_send,
                    input ready);
    modport sink (input valid, sda_in, cmd_valid, command, tx_byte, ack_to_send,
                  output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       timeout;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                    nack_seen, timeout, input ready);
    modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  nack_seen, timeout, output ready);
endinterface

@@ rtl/i2cm_front.sv @@
// tick intake: classifies each item and holds it in a two-entry queue
module i2cm_front
(
    input  logic                clk,
    input  logic                rst_n,
    i2cm_in_if.sink             in_ch,
    output i2cm_pkg::tick_req_t q_req,
    input  logic                q_ready
);

    i2cm_pkg::tick_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    i2cm_pkg::tick_t tick;
    logic            push;
    logic            pop;

    always_comb
    begin
        tick.sda = in_ch.sda_in;
        tick.tx  = in_ch.tx_byte;
        tick.ack = in_ch.ack_to_send;
        if (!in_ch.cmd_valid)
        begin
            tick.kind = i2cm_pkg::KIND_NONE;
        end
        else
        begin
            case (in_ch.command)
                i2cm_pkg::CMD_START: tick.kind = i2cm_pkg::KIND_START;
                i2cm_pkg::CMD_STOP:  tick.kind = i2cm_pkg::KIND_STOP;
                i2cm_pkg::CMD_WRITE: tick.kind = i2cm_pkg::KIND_WRITE;
                default:             tick.kind = i2cm_pkg::KIND_READ;
            endcase
        end
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_req.valid = (count_reg != 2'd0);
    assign q_req.data  = entry_reg[rd_ptr_reg];
    assign pop         = q_req.valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= tick;
        end
    end

endmodule

@@ rtl/i2cm_back.sv @@
// bus sequencer: steps once per queued tick and registers the result item
module i2cm_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  i2cm_pkg::tick_req_t                  q_req,
    output logic                                 q_ready,
    input  logic                                 cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_data,
    i2cm_out_if.source                           out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START1,
        ST_START2,
        ST_STOP1,
        ST_STOP2,
        ST_TSTOP1,
        ST_TSTOP2,
        ST_WR_LOW1,
        ST_WR_HIGH,
        ST_WR_LOW2,
        ST_ACK_WAIT,
        ST_RD_LOW1,
        ST_RD_HIGH,
        ST_RD_LOW2
    } state_t;

    state_t                             state_reg, state_next;
    logic [i2cm_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [i2cm_pkg::BITCNT_W-1:0]      bitcnt_reg, bitcnt_next;
    logic [i2cm_pkg::BYTE_W-1:0]        shift_reg, shift_next;
    logic [i2cm_pkg::ACK_W-1:0]         ackcnt_reg, ackcnt_next;
    logic                               scl_reg, scl_next;
    logic                               sda_reg, sda_next;
    logic                               acklat_reg, acklat_next;
    logic [i2cm_pkg::PHASE_W-1:0]       phase_ticks_reg;
    logic [i2cm_pkg::ACK_W-1:0]         ack_limit_reg;
    logic                               out_valid_reg;
    i2cm_pkg::result_t                  res_reg, res_next;

    logic [i2cm_pkg::PHASE_W-1:0]       phase_len;
    logic [i2cm_pkg::ACK_W:0]           ack_inc;
    logic                               do_ack;
    logic                               step;
    i2cm_pkg::tick_t                    tk;

    assign tk        = q_req.data;
    assign q_ready   = !out_valid_reg || out_ch.ready;
    assign step      = q_req.valid && q_ready;
    assign phase_len = (phase_ticks_reg == '0) ? {{(i2cm_pkg::PHASE_W-1){1'b0}}, 1'b1}
                                               : phase_ticks_reg;
    assign ack_inc   = {1'b0, ackcnt_reg} + {{i2cm_pkg::ACK_W{1'b0}}, 1'b1};

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        bitcnt_next = bitcnt_reg;
        shift_next  = shift_reg;
        ackcnt_next = ackcnt_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        acklat_next = acklat_reg;
        res_next    = '0;
        do_ack      = 1'b0;

        if (state_reg == ST_IDLE)
        begin
            phase_next = {{(i2cm_pkg::PHASE_W-1){1'b0}}, 1'b1};
            case (tk.kind)
                i2cm_pkg::KIND_START:
                begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    state_next = ST_START1;
                end
                i2cm_pkg::KIND_STOP:
                begin
                    sda_next   = 1'b0;
                    scl_next   = 1'b1;
                    state_next = ST_STOP1;
                end
                i2cm_pkg::KIND_WRITE:
                begin
                    shift_next  = tk.tx;
                    bitcnt_next = '0;
                    ackcnt_next = '0;
                    sda_next    = tk.tx[i2cm_pkg::BYTE_W-1];
                    scl_next    = 1'b0;
                    state_next  = ST_WR_LOW1;
                end
                i2cm_pkg::KIND_READ:
                begin
                    shift_next  = '0;
                    bitcnt_next = '0;
                    acklat_next = tk.ack;
                    sda_next    = 1'b1;
                    scl_next    = 1'b0;
                    state_next  = ST_RD_LOW1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (state_reg == ST_ACK_WAIT)
        begin
            do_ack = 1'b1;
        end
        else if (phase_reg < phase_len)
        begin
            phase_next = phase_reg + {{(i2cm_pkg::PHASE_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            phase_next = {{(i2cm_pkg::PHASE_W-1){1'b0}}, 1'b1};
            case (state_reg)
                ST_START1:
                begin
                    sda_next   = 1'b0;
                    state_next = ST_START2;
                end
                ST_START2:
                begin
                    scl_next      = 1'b0;
                    state_next    = ST_IDLE;
                    phase_next    = '0;
                    res_next.done = 1'b1;
                end
                ST_STOP1:
                begin
                    sda_next   = 1'b1;
                    state_next = ST_STOP2;
                end
                ST_STOP2:
                begin
                    state_next    = ST_IDLE;
                    phase_next    = '0;
                    res_next.done = 1'b1;
                end
                ST_TSTOP1:
                begin
                    sda_next   = 1'b1;
                    state_next = ST_TSTOP2;
                end
                ST_TSTOP2:
                begin
                    state_next       = ST_IDLE;
                    phase_next       = '0;
                    res_next.done    = 1'b1;
                    res_next.nack    = 1'b1;
                    res_next.timeout = 1'b1;
                end
                ST_WR_LOW1:
                begin
                    scl_next   = 1'b1;
                    state_next = ST_WR_HIGH;
                end
                ST_WR_HIGH:
                begin
                    if (bitcnt_reg[i2cm_pkg::BITCNT_W-1])
                    begin
                        do_ack = 1'b1;
                    end
                    else
                    begin
                        scl_next   = 1'b0;
                        state_next = ST_WR_LOW2;
                    end
                end
                ST_WR_LOW2:
                begin
                    shift_next  = {shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
                    bitcnt_next = bitcnt_reg + {{(i2cm_pkg::BITCNT_W-1){1'b0}}, 1'b1};
                    // release sda for the acknowledge slot after the last bit
                    sda_next    = bitcnt_next[i2cm_pkg::BITCNT_W-1] ? 1'b1
                                  : shift_reg[i2cm_pkg::BYTE_W-2];
                    state_next  = ST_WR_LOW1;
                end
                ST_RD_LOW1:
                begin
                    scl_next   = 1'b1;
                    state_next = ST_RD_HIGH;
                end
                ST_RD_HIGH:
                begin
                    if (!bitcnt_reg[i2cm_pkg::BITCNT_W-1])
                    begin
                        shift_next = {shift_reg[i2cm_pkg::BYTE_W-2:0], tk.sda};
                    end
                    scl_next   = 1'b0;
                    state_next = ST_RD_LOW2;
                end
                ST_RD_LOW2:
                begin
                    if (bitcnt_reg[i2cm_pkg::BITCNT_W-1])
                    begin
                        state_next    = ST_IDLE;
                        phase_next    = '0;
                        res_next.done = 1'b1;
                        res_next.rx   = shift_reg;
                    end
                    else
                    begin
                        bitcnt_next = bitcnt_reg + {{(i2cm_pkg::BITCNT_W-1){1'b0}}, 1'b1};
                        if (bitcnt_next[i2cm_pkg::BITCNT_W-1])
                        begin
                            sda_next = acklat_reg;
                        end
                        state_next = ST_RD_LOW1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    phase_next = '0;
                end
            endcase
        end

        // acknowledge sample, shared by the first sample and the wait ticks
        if (do_ack)
        begin
            if (!tk.sda)
            begin
                scl_next      = 1'b0;
                state_next    = ST_IDLE;
                phase_next    = '0;
                res_next.done = 1'b1;
            end
            else if (ack_inc > {1'b0, ack_limit_reg})
            begin
                sda_next   = 1'b0;
                state_next = ST_TSTOP1;
                phase_next = {{(i2cm_pkg::PHASE_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                ackcnt_next = ack_inc[i2cm_pkg::ACK_W-1:0];
                state_next  = ST_ACK_WAIT;
                phase_next  = '0;
            end
        end

        res_next.scl  = scl_next;
        res_next.sda  = sda_next;
        res_next.busy = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= '0;
            bitcnt_reg      <= '0;
            shift_reg       <= '0;
            ackcnt_reg      <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            acklat_reg      <= 1'b0;
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RST;
            ack_limit_reg   <= i2cm_pkg::ACK_WAIT_LIMIT_RST;
            out_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    i2cm_pkg::CFG_PHASE_TICKS:
                        phase_ticks_reg <= cfg_data[i2cm_pkg::PHASE_W-1:0];
                    i2cm_pkg::CFG_ACK_WAIT_LIMIT:
                        ack_limit_reg <= cfg_data[i2cm_pkg::ACK_W-1:0];
                    default:
                        ack_limit_reg <= ack_limit_reg;
                endcase
            end
            if (step)
            begin
                state_reg     <= state_next;
                phase_reg     <= phase_next;
                bitcnt_reg    <= bitcnt_next;
                shift_reg     <= shift_next;
                ackcnt_reg    <= ackcnt_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                acklat_reg    <= acklat_next;
                res_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.scl_out   = res_reg.scl;
    assign out_ch.sda_out   = res_reg.sda;
    assign out_ch.busy_res  = res_reg.busy;
    assign out_ch.done_res  = res_reg.done;
    assign out_ch.rx_byte   = res_reg.rx;
    assign out_ch.nack_seen = res_reg.nack;
    assign out_ch.timeout   = res_reg.timeout;

endmodule

@@ rtl/i2c_master_bit_engine.sv @@
// top level of the i2c master bit engine: tick intake, queue and bus sequencer
//
//  channel   dir   handshake          carries
//  in_ch     in    valid/ready        sda_in, cmd_valid, command, tx_byte, ack_to_send
//  out_ch    out   valid/ready        scl_out, sda_out, busy_res, done_res, rx_byte,
//                                     nack_seen, timeout
//  cfg       in    cfg_we             cfg_idx, cfg_data (phase_ticks, ack_wait_limit)
//
// one tick item in and one result item out per clock, sustained while out_ch is ready
// an item is registered in the intake queue and then again in the result register
// one sequencer step per clock while step is high, through a single state update path
// reset clears the queue, the sequencer and the result register; no clearing pass
// a stalled output holds the result register, the queue absorbs up to two further items
module i2c_master_bit_engine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    i2cm_in_if.sink                              in_ch,
    i2cm_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    i2cm_pkg::tick_req_t q_req;
    logic                q_ready;

    i2cm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_req   (q_req),
        .q_ready (q_ready)
    );

    i2cm_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_req    (q_req),
        .q_ready  (q_ready),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .out_ch   (out_ch)
    );

    // a timeout always closes the write with a no-acknowledge
    a_timeout_nack: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.timeout |-> out_ch.nack_seen && out_ch.done_res)
        else $error("timeout without nack and done");

    // a completing item leaves the sequencer idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
        else $error("done while still busy");

    // read data only shows on the completing item
    a_rx_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.rx_byte != 8'd0) |-> out_ch.done_res)
        else $error("rx byte outside completion");

    // the queue can never be full while the result side drains every cycle
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready && $past(out_ch.ready) && $past(out_ch.ready, 2) |-> in_ch.ready)
        else $error("intake stalled with free result side");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the i2c master bit engine: tick stimulus, bus predictor, scoreboard
`timescale 1ns / 100ps

module testbench;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START1,
        S_START2,
        S_STOP1,
        S_STOP2,
        S_TSTOP1,
        S_TSTOP2,
        S_WR_LOW1,
        S_WR_HIGH,
        S_WR_LOW2,
        S_ACK_WAIT,
        S_RD_LOW1,
        S_RD_HIGH,
        S_RD_LOW2
    } seq_state_t;

    typedef struct packed {
        logic        sda;
        logic        cv;
        logic [1:0]  cmd;
        logic [7:0]  tx;
        logic        ak;
    } tick_in_t;

    typedef struct {
        tick_in_t          t;
        int                hold;
        bit                typed;
        i2cm_pkg::result_t res;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data;

    i2cm_in_if  in_ch ();
    i2cm_out_if out_ch ();

    i2c_master_bit_engine u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // predicted bus engine state, starting from its reset values
    logic [i2cm_pkg::PHASE_W-1:0] cfg_phase = i2cm_pkg::PHASE_TICKS_RST;
    logic [i2cm_pkg::ACK_W-1:0]   cfg_limit = i2cm_pkg::ACK_WAIT_LIMIT_RST;
    seq_state_t         seq_st    = S_IDLE;
    logic [9:0]         ph_cnt    = '0;
    logic [3:0]         bit_cnt   = '0;
    logic [7:0]         shreg     = '0;
    logic [7:0]         ackw_cnt  = '0;
    logic               scl_lvl   = 1'b1;
    logic               sda_lvl   = 1'b1;
    logic               ack_lat   = 1'b0;
    logic               ev_done, ev_nack, ev_to;
    logic [7:0]         ev_rx;

    i2cm_pkg::result_t bus_expect [$];
    i2cm_pkg::result_t exp_res;

    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    bit  short_only   = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  hold_left    = 0;
    int  ack_highs_plan = 0;
    int  ack_highs_sent = 0;
    int  mismatches   = 0;
    int  n_ticks      = 0;
    int  n_ignored    = 0;
    int  n_acked      = 0;
    int  n_timeouts   = 0;
    int  n_reads      = 0;
    int  cmd_count [4] = '{0, 0, 0, 0};

    // fields: sda, cmd valid, command, tx byte, ack to send
    dir_row_t dir_rows [14] = '{
        // idle right after reset, stray command fields without cmd_valid
        '{'{1'b1, 1'b0, i2cm_pkg::CMD_WRITE, 8'h00, 1'b0},  1, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
        '{'{1'b1, 1'b1, i2cm_pkg::CMD_START, 8'h00, 1'b0},  1, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
        // stop offered while the start runs is dropped
        '{'{1'b0, 1'b1, i2cm_pkg::CMD_STOP,  8'hFF, 1'b1},  1, 1'b1,
          '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
        '{'{1'b0, 1'b0, i2cm_pkg::CMD_START, 8'h00, 1'b0},  1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0}},
        // all ones written, ack left high: a zero wait limit times out on the first sample
        '{'{1'b1, 1'b1, i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1},  1, 1'b0, '0},
        '{'{1'b1, 1'b0, i2cm_pkg::CMD_READ,  8'h00, 1'b0}, 30, 1'b0, '0},
        // all zeros written and acknowledged
        '{'{1'b0, 1'b1, i2cm_pkg::CMD_WRITE, 8'h00, 1'b0},  1, 1'b0, '0},
        '{'{1'b0, 1'b0, i2cm_pkg::CMD_READ,  8'hFF, 1'b1}, 30, 1'b0, '0},
        // read of all ones with ack, then all zeros with nack
        '{'{1'b1, 1'b1, i2cm_pkg::CMD_READ,  8'hA5, 1'b0},  1, 1'b0, '0},
        '{'{1'b1, 1'b0, i2cm_pkg::CMD_READ,  8'h5A, 1'b1}, 30, 1'b0, '0},
        '{'{1'b0, 1'b1, i2cm_pkg::CMD_READ,  8'h00, 1'b1},  1, 1'b0, '0},
        '{'{1'b0, 1'b0, i2cm_pkg::CMD_STOP,  8'h00, 1'b0}, 30, 1'b0, '0},
        '{'{1'b1, 1'b1, i2cm_pkg::CMD_STOP,  8'h00, 1'b0},  1, 1'b0, '0},
        '{'{1'b1, 1'b0, i2cm_pkg::CMD_STOP,  8'h00, 1'b0},  4, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void enter(input seq_state_t s);
        seq_st = s;
        ph_cnt = 10'd1;
    endfunction

    function automatic void wrap_up();
        seq_st  = S_IDLE;
        ph_cnt  = '0;
        ev_done = 1'b1;
    endfunction

    function automatic void ack_check(input logic sda);
        if (!sda)
        begin
            scl_lvl = 1'b0;
            wrap_up();
            n_acked++;
        end
        else if ({1'b0, ackw_cnt} + 9'd1 > {1'b0, cfg_limit})
        begin
            // too many high samples: pull sda low with scl high and stop
            sda_lvl = 1'b0;
            enter(S_TSTOP1);
        end
        else
        begin
            ackw_cnt = ackw_cnt + 8'd1;
            seq_st   = S_ACK_WAIT;
            ph_cnt   = '0;
        end
    endfunction

    function automatic i2cm_pkg::result_t bus_step(input tick_in_t t);
        i2cm_pkg::result_t r;
        logic [9:0]        p;
        p = (cfg_phase == '0) ? 10'd1 : cfg_phase;
        ev_done = 1'b0;
        ev_nack = 1'b0;
        ev_to   = 1'b0;
        ev_rx   = '0;
        if (seq_st != S_IDLE && t.cv)
            n_ignored++;
        if (seq_st == S_IDLE)
        begin
            if (t.cv)
            begin
                cmd_count[t.cmd]++;
                case (t.cmd)
                    i2cm_pkg::CMD_START:
                    begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                        enter(S_START1);
                    end
                    i2cm_pkg::CMD_STOP:
                    begin
                        sda_lvl = 1'b0;
                        scl_lvl = 1'b1;
                        enter(S_STOP1);
                    end
                    i2cm_pkg::CMD_WRITE:
                    begin
                        shreg    = t.tx;
                        bit_cnt  = '0;
                        ackw_cnt = '0;
                        sda_lvl  = t.tx[7];
                        scl_lvl  = 1'b0;
                        enter(S_WR_LOW1);
                    end
                    default:
                    begin
                        shreg   = '0;
                        bit_cnt = '0;
                        ack_lat = t.ak;
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b0;
                        enter(S_RD_LOW1);
                    end
                endcase
            end
        end
        else if (seq_st == S_ACK_WAIT)
            ack_check(t.sda);
        else if (ph_cnt < p)
            ph_cnt = ph_cnt + 10'd1;
        else
        begin
            case (seq_st)
                S_START1:
                begin
                    sda_lvl = 1'b0;
                    enter(S_START2);
                end
                S_START2:
                begin
                    scl_lvl = 1'b0;
                    wrap_up();
                end
                S_STOP1:
                begin
                    sda_lvl = 1'b1;
                    enter(S_STOP2);
                end
                S_STOP2:
                    wrap_up();
                S_TSTOP1:
                begin
                    sda_lvl = 1'b1;
                    enter(S_TSTOP2);
                end
                S_TSTOP2:
                begin
                    wrap_up();
                    ev_nack = 1'b1;
                    ev_to   = 1'b1;
                    n_timeouts++;
                end
                S_WR_LOW1:
                begin
                    scl_lvl = 1'b1;
                    enter(S_WR_HIGH);
                end
                S_WR_HIGH:
                    if (bit_cnt >= 4'd8)
                        ack_check(t.sda);
                    else
                    begin
                        scl_lvl = 1'b0;
                        enter(S_WR_LOW2);
                    end
                S_WR_LOW2:
                begin
                    shreg   = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    sda_lvl = (bit_cnt >= 4'd8) ? 1'b1 : shreg[7];
                    enter(S_WR_LOW1);
                end
                S_RD_LOW1:
                begin
                    scl_lvl = 1'b1;
                    enter(S_RD_HIGH);
                end
                S_RD_HIGH:
                begin
                    if (bit_cnt < 4'd8)
                        shreg = {shreg[6:0], t.sda};
                    scl_lvl = 1'b0;
                    enter(S_RD_LOW2);
                end
                S_RD_LOW2:
                    if (bit_cnt >= 4'd8)
                    begin
                        wrap_up();
                        ev_rx = shreg;
                        n_reads++;
                    end
                    else
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        // ack slot of the read: drive the requested level
                        if (bit_cnt >= 4'd8)
                            sda_lvl = ack_lat;
                        enter(S_RD_LOW1);
                    end
                default:
                begin
                    seq_st = S_IDLE;
                    ph_cnt = '0;
                end
            endcase
        end
        r.scl     = scl_lvl;
        r.sda     = sda_lvl;
        r.busy    = (seq_st != S_IDLE);
        r.done    = ev_done;
        r.rx      = ev_rx;
        r.nack    = ev_nack;
        r.timeout = ev_to;
        return r;
    endfunction

    // next tick, shaped by where the predicted engine stands
    function automatic tick_in_t make_tick(input bit cmds_ok);
        tick_in_t   t;
        logic [9:0] p;
        int         pick;
        p    = (cfg_phase == '0) ? 10'd1 : cfg_phase;
        t.sda = 1'($urandom_range(1));
        t.cmd = 2'($urandom_range(3));
        t.tx  = 8'($urandom_range(255));
        t.ak  = 1'($urandom_range(1));
        if (seq_st == S_IDLE)
        begin
            t.cv = cmds_ok && ($urandom_range(99) < 80);
            if (short_only)
                t.cmd = $urandom_range(1) ? i2cm_pkg::CMD_STOP : i2cm_pkg::CMD_START;
            if (t.cv && t.cmd == i2cm_pkg::CMD_WRITE)
            begin
                // plan how many high samples the slave gives before acking
                pick = $urandom_range(9);
                ack_highs_sent = 0;
                if (pick < 4)
                    ack_highs_plan = 0;
                else if (pick < 7)
                    ack_highs_plan = $urandom_range(cfg_limit);
                else
                    ack_highs_plan = 300;
            end
        end
        else
        begin
            t.cv = ($urandom_range(3) == 0);
            if (seq_st == S_ACK_WAIT ||
                (seq_st == S_WR_HIGH && bit_cnt >= 4'd8 && ph_cnt >= p))
            begin
                t.sda = (ack_highs_sent < ack_highs_plan);
                ack_highs_sent++;
            end
        end
        return t;
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_tick(input tick_in_t t, input bit typed,
                             input i2cm_pkg::result_t typed_res);
        i2cm_pkg::result_t got;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sda_in      <= t.sda;
        in_ch.cmd_valid   <= t.cv;
        in_ch.command     <= t.cmd;
        in_ch.tx_byte     <= t.tx;
        in_ch.ack_to_send <= t.ak;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        got = bus_step(t);
        bus_expect.push_back(typed ? typed_res : got);
        n_ticks++;
    endtask

    task automatic wait_results_in();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (bus_expect.size() != 0);
    endtask

    task automatic bring_to_idle();
        while (seq_st != S_IDLE)
            send_tick(make_tick(1'b0), 1'b0, '0);
        wait_results_in();
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [i2cm_pkg::PHASE_W-1:0] phase,
                               input logic [i2cm_pkg::ACK_W-1:0] limit);
        bring_to_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= i2cm_pkg::CFG_PHASE_TICKS;
        cfg_data <= phase;
        @(posedge clk);
        cfg_idx  <= i2cm_pkg::CFG_ACK_WAIT_LIMIT;
        cfg_data <= {2'b00, limit};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_phase = phase;
        cfg_limit = limit;
    endtask

    task automatic cmp_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
        end
    endtask

    // result side: scoreboard check and ready with random or long stalls
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (bus_expect.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result item, expected none got scl %0b sda %0b",
                         $time, out_ch.scl_out, out_ch.sda_out);
            end
            else
            begin
                exp_res = bus_expect.pop_front();
                cmp_field("scl_out",   exp_res.scl,     out_ch.scl_out);
                cmp_field("sda_out",   exp_res.sda,     out_ch.sda_out);
                cmp_field("busy_res",  exp_res.busy,    out_ch.busy_res);
                cmp_field("done_res",  exp_res.done,    out_ch.done_res);
                cmp_field("rx_byte",   exp_res.rx,      out_ch.rx_byte);
                cmp_field("nack_seen", exp_res.nack,    out_ch.nack_seen);
                cmp_field("timeout",   exp_res.timeout, out_ch.timeout);
            end
        end
        if (long_hold_req && !long_hold_done)
        begin
            hold_left      = 250;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= i2cm_pkg::CFG_PHASE_TICKS;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.sda_in      <= 1'b1;
        in_ch.cmd_valid   <= 1'b0;
        in_ch.command     <= i2cm_pkg::CMD_START;
        in_ch.tx_byte     <= '0;
        in_ch.ack_to_send <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 31;
        recv_gap_pct = 69;
        // zero phase length behaves as one tick
        reconfigure(10'd0, 8'd0);
        foreach (dir_rows[i])
            repeat (dir_rows[i].hold)
                send_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].res);

        reconfigure(10'd1, 8'd3);
        for (int i = 0; i < 340; i++)
        begin
            // long output stall while ticks keep coming
            if (i == 100)
                long_hold_req = 1'b1;
            send_tick(make_tick(1'b1), 1'b0, '0);
        end

        send_gap_pct = 69;
        recv_gap_pct = 31;
        reconfigure(10'd3, 8'd17);
        for (int i = 0; i < 340; i++)
        begin
            if (i == 150)
                wait_results_in();
            send_tick(make_tick(1'b1), 1'b0, '0);
        end

        send_gap_pct = 0;
        recv_gap_pct = 0;
        reconfigure(10'd2, 8'd255);
        for (int i = 0; i < 360; i++)
            send_tick(make_tick(1'b1), 1'b0, '0);

        // longer phases: keep to start and stop so the run stays short
        short_only = 1'b1;
        reconfigure(10'd31, 8'd250);
        for (int i = 0; i < 160; i++)
            send_tick(make_tick(1'b1), 1'b0, '0);

        bring_to_idle();
        $display("%0d ticks: %0d start, %0d stop, %0d write, %0d read commands, %0d dropped busy",
                 n_ticks, cmd_count[i2cm_pkg::CMD_START], cmd_count[i2cm_pkg::CMD_STOP],
                 cmd_count[i2cm_pkg::CMD_WRITE], cmd_count[i2cm_pkg::CMD_READ], n_ignored);
        $display("%0d writes acked, %0d ack timeouts, %0d reads done, phase length 0 to 31",
                 n_acked, n_timeouts, n_reads);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
